[rtl/tflc_pkg.sv]
package tflc_pkg;

   localparam int COUNTER_BITS = 32;
   localparam int TIMEOUT_BITS = 32;
   localparam int CMP_BITS = (COUNTER_BITS > TIMEOUT_BITS) ? COUNTER_BITS : TIMEOUT_BITS;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [COUNTER_BITS-1:0] counter_type;
   typedef logic [TIMEOUT_BITS-1:0] timeout_type;
   typedef logic [1:0] tank_state_type;
   typedef logic [2:0] fault_code_type;
   typedef logic [1:0] reg_index_type;

   localparam tank_state_type ST_EMPTY = 2'd0;
   localparam tank_state_type ST_MID   = 2'd1;
   localparam tank_state_type ST_FULL  = 2'd2;
   localparam tank_state_type ST_FAULT = 2'd3;

   localparam fault_code_type FAULT_NONE         = 3'd0;
   localparam fault_code_type FAULT_HIGH_EMPTY   = 3'd1;
   localparam fault_code_type FAULT_LOW_TIMEOUT  = 3'd2;
   localparam fault_code_type FAULT_FILL_TIMEOUT = 3'd3;
   localparam fault_code_type FAULT_LOW_LOST     = 3'd4;

   localparam reg_index_type REG_CONTINUOUS_MODE = 2'd0;
   localparam reg_index_type REG_LOW_TIMEOUT     = 2'd1;
   localparam reg_index_type REG_FILL_TIMEOUT    = 2'd2;

   localparam timeout_type LOW_TIMEOUT_RESET  = 32'd60000;
   localparam timeout_type FILL_TIMEOUT_RESET = 32'd2400000;

endpackage

[rtl/tflc_if.sv]
interface tflc_req_if;
   logic valid;
   logic ready;
   logic high_sensor;
   logic low_sensor;

   modport source (output valid, output high_sensor, output low_sensor, input ready);
   modport sink (input valid, input high_sensor, input low_sensor, output ready);
endinterface

interface tflc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] tank_state;
   logic       filling;
   logic       relay_on;
   logic       send_keepalive;
   logic [2:0] fault_code;

   modport source (output valid, output tank_state, output filling, output relay_on,
                   output send_keepalive, output fault_code, input ready);
   modport sink (input valid, input tank_state, input filling, input relay_on,
                 input send_keepalive, input fault_code, output ready);
endinterface

[rtl/tank_fill_level_controller.sv]
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   high_sensor, low_sensor
// rsp       out        valid/ready   tank_state, filling, relay_on, send_keepalive, fault_code
// csr       in         APB write/rd  continuous_mode, low_sensor_timeout_ms, fill_timeout_ms
//
// One item per cycle is accepted while results are taken; each item passes through the
// input register and then the result register, from which its result is offered.
// The state update is done as an item leaves the input register for the result register.
// A stalled result holds the input register, and the next item is still taken when
// the result is taken in the same cycle.
// Synchronous reset clears the tank state to intermediate and restores register defaults.
module tank_fill_level_controller
   import tflc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   tflc_req_if.sink                 req,
   tflc_rsp_if.source               rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam counter_type COUNTER_MAX = '1;

   logic           continuous_ff;
   timeout_type    low_timeout_ff;
   timeout_type    fill_timeout_ff;
   reg_index_type  csr_index;
   logic           csr_write;

   logic           in_valid_ff;
   logic           high_ff;
   logic           low_ff;
   logic           advance;

   tank_state_type mode_ff, mode_in;
   logic           came_from_empty_ff, came_from_empty_in;
   counter_type    elapsed_ff, elapsed_in, elapsed_inc;
   logic           fill_ff, fill_in;
   logic           relay_ff, relay_in;
   fault_code_type fault_ff, fault_in;

   logic           out_valid_ff;
   tank_state_type out_state_ff;
   logic           out_fill_ff;
   logic           out_relay_ff;
   logic           out_keepalive_ff;
   fault_code_type out_fault_ff;

   logic           low_expired;
   logic           fill_expired;
   logic           take_turn;
   tank_state_type target;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         continuous_ff   <= 1'b0;
         low_timeout_ff  <= LOW_TIMEOUT_RESET;
         fill_timeout_ff <= FILL_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CONTINUOUS_MODE: continuous_ff <= csr_pwdata[0];
            REG_LOW_TIMEOUT:     low_timeout_ff <= csr_pwdata[TIMEOUT_BITS-1:0];
            REG_FILL_TIMEOUT:    fill_timeout_ff <= csr_pwdata[TIMEOUT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CONTINUOUS_MODE: csr_prdata = {{(CSR_DATA_BITS-1){1'b0}}, continuous_ff};
         REG_LOW_TIMEOUT:     csr_prdata = CSR_DATA_BITS'(low_timeout_ff);
         REG_FILL_TIMEOUT:    csr_prdata = CSR_DATA_BITS'(fill_timeout_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         high_ff <= req.high_sensor;
         low_ff  <= req.low_sensor;
      end
   end

   assign elapsed_inc  = (elapsed_ff == COUNTER_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign low_expired  = CMP_BITS'(elapsed_inc) > CMP_BITS'(low_timeout_ff);
   assign fill_expired = CMP_BITS'(elapsed_inc) > CMP_BITS'(fill_timeout_ff);

   always_comb begin
      take_turn = 1'b0;
      target    = mode_ff;
      fault_in  = fault_ff;
      unique case (mode_ff)
         ST_EMPTY: begin
            if (high_ff) begin
               take_turn = 1'b1;
               target    = ST_FAULT;
               fault_in  = FAULT_HIGH_EMPTY;
            end else if (low_ff) begin
               take_turn = 1'b1;
               target    = ST_MID;
            end else if (low_expired) begin
               take_turn = 1'b1;
               target    = ST_FAULT;
               fault_in  = FAULT_LOW_TIMEOUT;
            end
         end
         ST_MID: begin
            if (high_ff) begin
               take_turn = 1'b1;
               target    = ST_FULL;
            end else if (!low_ff) begin
               take_turn = 1'b1;
               target    = ST_EMPTY;
            end else if (came_from_empty_ff && fill_expired) begin
               take_turn = 1'b1;
               target    = ST_FAULT;
               fault_in  = FAULT_FILL_TIMEOUT;
            end
         end
         ST_FULL: begin
            if (!low_ff) begin
               take_turn = 1'b1;
               target    = ST_FAULT;
               fault_in  = FAULT_LOW_LOST;
            end else if (!high_ff) begin
               take_turn = 1'b1;
               target    = ST_MID;
            end
         end
         ST_FAULT: begin
         end
      endcase
   end

   always_comb begin
      mode_in            = mode_ff;
      came_from_empty_in = came_from_empty_ff;
      elapsed_in         = elapsed_inc;
      fill_in            = fill_ff;
      relay_in           = relay_ff;
      if (take_turn) begin
         mode_in            = target;
         came_from_empty_in = (mode_ff == ST_EMPTY);
         if (target == ST_EMPTY) begin
            fill_in    = 1'b1;
            elapsed_in = '0;
            if (!continuous_ff) begin
               relay_in = 1'b1;
            end
         end else if (target == ST_FULL || target == ST_FAULT) begin
            fill_in = 1'b0;
            if (!continuous_ff) begin
               relay_in = 1'b0;
            end
         end else if (mode_ff == ST_EMPTY) begin
            elapsed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= ST_MID;
         came_from_empty_ff <= 1'b0;
         elapsed_ff         <= '0;
         fill_ff            <= 1'b0;
         relay_ff           <= 1'b0;
         fault_ff           <= FAULT_NONE;
      end else if (advance) begin
         mode_ff            <= mode_in;
         came_from_empty_ff <= came_from_empty_in;
         elapsed_ff         <= elapsed_in;
         fill_ff            <= fill_in;
         relay_ff           <= relay_in;
         fault_ff           <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff     <= mode_in;
         out_fill_ff      <= fill_in;
         out_relay_ff     <= relay_in;
         out_keepalive_ff <= continuous_ff && fill_in;
         out_fault_ff     <= fault_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.tank_state     = out_state_ff;
   assign rsp.filling        = out_fill_ff;
   assign rsp.relay_on       = out_relay_ff;
   assign rsp.send_keepalive = out_keepalive_ff;
   assign rsp.fault_code     = out_fault_ff;

endmodule

[tb/sv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tflc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 74;
   localparam int DIRECTED_ROWS = 22;
   localparam reg_index_type REG_UNUSED = 2'd3;

   typedef struct packed {
      tank_state_type st;
      logic           filling;
      logic           relay_on;
      logic           keepalive;
      fault_code_type code;
   } tank_status_type;

   typedef struct packed {
      tank_state_type st;
      logic           from_empty;
      counter_type    elapsed;
      logic           fill_on;
      logic           relay;
      fault_code_type code;
   } tank_model_type;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            hi;
      logic            lo;
      reg_index_type   idx;
      timeout_type     value;
      logic            typed;
      tank_status_type want;
   } directed_row_type;

   localparam tank_status_type NO_STATUS = '0;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   tflc_req_if req_if();
   tflc_rsp_if rsp_if();

   logic             cfg_cont;
   timeout_type      cfg_low;
   timeout_type      cfg_fill;
   tank_model_type   tank;
   tank_status_type  awaited_status[$];
   directed_row_type directed_rows[DIRECTED_ROWS];

   int send_idle_pct;
   int stall_pct;
   int stall_left;
   int quiet_cycles;
   int mismatches;
   int items_sent;
   int results_seen;
   int settings_applied;
   int keepalives_seen;
   fault_code_type last_code;

   tank_fill_level_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic tank_model_type enter_state(tank_model_type cur, tank_state_type to);
      tank_model_type n;
      n = cur;
      n.from_empty = (cur.st == ST_EMPTY);
      n.st = to;
      if (to == ST_EMPTY) begin
         n.fill_on = 1'b1;
         if (!cfg_cont) n.relay = 1'b1;
         n.elapsed = '0;
      end else if (to == ST_FULL || to == ST_FAULT) begin
         if (!cfg_cont) n.relay = 1'b0;
         n.fill_on = 1'b0;
      end
      return n;
   endfunction

   function automatic tank_model_type tank_step(tank_model_type cur, logic hi, logic lo);
      tank_model_type n;
      n = cur;
      if (n.elapsed != '1) n.elapsed = n.elapsed + 1'b1;
      case (cur.st)
         ST_EMPTY: begin
            if (hi) begin
               n.code = FAULT_HIGH_EMPTY;
               n = enter_state(n, ST_FAULT);
            end else if (lo) begin
               n.elapsed = '0;
               n = enter_state(n, ST_MID);
            end else if (n.elapsed > cfg_low) begin
               n.code = FAULT_LOW_TIMEOUT;
               n = enter_state(n, ST_FAULT);
            end
         end
         ST_MID: begin
            if (hi) begin
               n = enter_state(n, ST_FULL);
            end else if (!lo) begin
               n = enter_state(n, ST_EMPTY);
            end else if (n.from_empty && n.elapsed > cfg_fill) begin
               n.code = FAULT_FILL_TIMEOUT;
               n = enter_state(n, ST_FAULT);
            end
         end
         ST_FULL: begin
            if (!lo) begin
               n.code = FAULT_LOW_LOST;
               n = enter_state(n, ST_FAULT);
            end else if (!hi) begin
               n = enter_state(n, ST_MID);
            end
         end
         default: begin
         end
      endcase
      return n;
   endfunction

   // Mostly well-formed fill and drain cycles; unless faults are allowed, a tick that
   // would fault is replaced by one that keeps the tank out of fault.
   function automatic logic [1:0] choose_item(tank_model_type cur, bit may_fault);
      logic [1:0]     pick;
      int unsigned    roll;
      tank_model_type nxt;
      roll = $urandom_range(99);
      if (roll < 8 || cur.st == ST_FAULT) begin
         pick = 2'($urandom_range(3));
      end else begin
         case (cur.st)
            ST_EMPTY: pick = (roll < 35) ? 2'b01 : 2'b00;
            ST_MID:   pick = (roll < 25) ? 2'b11 : ((roll < 40) ? 2'b00 : 2'b01);
            default:  pick = (roll < 30) ? 2'b01 : 2'b11;
         endcase
      end
      nxt = tank_step(cur, pick[1], pick[0]);
      if (!may_fault && nxt.st == ST_FAULT && cur.st != ST_FAULT)
         pick = (cur.st == ST_EMPTY) ? 2'b01 : 2'b11;
      return pick;
   endfunction

   function automatic timeout_type pick_timeout();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return timeout_type'(1);
         default: return timeout_type'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(99) >= send_idle_pct) return 0;
      return ($urandom_range(11) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   task automatic push_item(logic hi, logic lo, logic typed, tank_status_type want);
      int              gap;
      tank_status_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.high_sensor <= hi;
      req_if.low_sensor <= lo;
      do @(posedge clock); while (!req_if.ready);
      tank = tank_step(tank, hi, lo);
      pred = '{tank.st, tank.fill_on, tank.relay, cfg_cont & tank.fill_on, tank.code};
      awaited_status.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, timeout_type value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CONTINUOUS_MODE: cfg_cont = value[0];
         REG_LOW_TIMEOUT:     cfg_low = value;
         REG_FILL_TIMEOUT:    cfg_fill = value;
         default: begin
         end
      endcase
      settings_applied++;
   endtask

   initial begin
      tank_status_type want;
      rsp_if.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else begin
            if (rsp_if.valid && rsp_if.ready) begin
               results_seen++;
               last_code = rsp_if.fault_code;
               if (rsp_if.send_keepalive === 1'b1) keepalives_seen++;
               if (awaited_status.size() == 0) begin
                  mismatches++;
                  $display("%0t tb: result with no item pending, expected none, actual %0d",
                           $time, rsp_if.tank_state);
               end else begin
                  want = awaited_status.pop_front();
                  check_field("tank_state", want.st, rsp_if.tank_state);
                  check_field("filling", want.filling, rsp_if.filling);
                  check_field("relay_on", want.relay_on, rsp_if.relay_on);
                  check_field("send_keepalive", want.keepalive, rsp_if.send_keepalive);
                  check_field("fault_code", want.code, rsp_if.fault_code);
               end
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_if.ready <= 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
               stall_left = ($urandom_range(15) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 2);
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type row;
      logic             cont_pick;
      timeout_type      low_pick;
      timeout_type      fill_pick;
      logic [1:0]       pick;
      int               ph;
      int               n;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.high_sensor = 1'b0;
      req_if.low_sensor = 1'b0;
      quiet_cycles = 0;
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      settings_applied = 0;
      keepalives_seen = 0;
      last_code = FAULT_NONE;
      send_idle_pct = 20;
      stall_pct = 20;
      cfg_cont = 1'b0;
      cfg_low = LOW_TIMEOUT_RESET;
      cfg_fill = FILL_TIMEOUT_RESET;
      tank = '{st: ST_MID, from_empty: 1'b0, elapsed: '0, fill_on: 1'b0, relay: 1'b0,
               code: FAULT_NONE};

      // Relay behavior across mode changes in the middle of a fill cycle, zero and
      // maximum timeouts, and a write to an unused register are covered here.
      directed_rows = '{
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b1,
           '{ST_MID, 1'b0, 1'b0, 1'b0, FAULT_NONE}},
         '{ROW_ITEM, 1'b1, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b1,
           '{ST_FULL, 1'b0, 1'b0, 1'b0, FAULT_NONE}},
         '{ROW_ITEM, 1'b1, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b1,
           '{ST_FULL, 1'b0, 1'b0, 1'b0, FAULT_NONE}},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b1,
           '{ST_MID, 1'b0, 1'b0, 1'b0, FAULT_NONE}},
         '{ROW_ITEM, 1'b0, 1'b0, REG_CONTINUOUS_MODE, '0, 1'b1,
           '{ST_EMPTY, 1'b1, 1'b1, 1'b0, FAULT_NONE}},
         '{ROW_WRITE, 1'b0, 1'b0, REG_LOW_TIMEOUT, '0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_WRITE, 1'b0, 1'b0, REG_FILL_TIMEOUT, '1, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b1, 1'b0, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_WRITE, 1'b0, 1'b0, REG_CONTINUOUS_MODE, 32'd1, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b0, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_WRITE, 1'b0, 1'b0, REG_CONTINUOUS_MODE, 32'd0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b0, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_WRITE, 1'b0, 1'b0, REG_CONTINUOUS_MODE, 32'd1, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b1, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_WRITE, 1'b0, 1'b0, REG_UNUSED, '1, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b1, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS},
         '{ROW_ITEM, 1'b0, 1'b0, REG_CONTINUOUS_MODE, '0, 1'b0, NO_STATUS}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            wait_drained();
            csr_write(row.idx, row.value);
         end else begin
            push_item(row.hi, row.lo, row.typed, row.want);
         end
      end

      // The last phase lets the tank fault, which then holds for the rest of the run.
      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         cont_pick = 1'($urandom_range(1));
         low_pick = pick_timeout();
         fill_pick = pick_timeout();
         if (ph == 0) begin
            cont_pick = 1'b0;
            low_pick = '1;
            fill_pick = '0;
         end else if (ph == 1) begin
            cont_pick = 1'b1;
            low_pick = timeout_type'(1);
            fill_pick = timeout_type'(1);
         end else if (ph == PHASES - 1) begin
            low_pick = timeout_type'($urandom_range(1, 6));
            fill_pick = timeout_type'($urandom_range(1, 6));
         end
         csr_write(REG_CONTINUOUS_MODE, timeout_type'(cont_pick));
         csr_write(REG_LOW_TIMEOUT, low_pick);
         csr_write(REG_FILL_TIMEOUT, fill_pick);
         send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
         stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = choose_item(tank, ph == PHASES - 1);
            push_item(pick[1], pick[0], 1'b0, NO_STATUS);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("tb: %0d ticks sent, %0d results checked, %0d register writes, %0d mismatches",
               items_sent, results_seen, settings_applied, mismatches);
      $display("tb: %0d keepalive requests seen, final fault code %0d",
               keepalives_seen, last_code);
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tflc_pkg.sv
rtl/tflc_if.sv
rtl/tank_fill_level_controller.sv
tb/sv/tb.sv
